FILE: hw/rtl/hdtm_pkg.sv
package hdtm_pkg;

  // Default sizing
  localparam int unsigned BYTE_CAP_DEF       = 4096;
  localparam int unsigned ENTRY_OVERHEAD_DEF = 32;
  localparam int unsigned ENTRY_SLOTS_DEF    = 128;

  // Widths of the sums formed from one request's lengths
  localparam int unsigned BYTES_W = 17;  // name bytes + value bytes
  localparam int unsigned ESIZE_W = 18;  // plus per-entry overhead
  localparam int unsigned SUM_W   = 19;  // used size plus entry size

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_SIZE   = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_DROP,
    ST_TAIL,
    ST_COMPACT,
    ST_PLACE,
    ST_LOOKUP,
    ST_LOOK_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] name_bytes;
    logic [15:0] value_bytes;
    logic [31:0] name_digest;
    logic [7:0]  lookup_index;
    logic [31:0] size_limit;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] data_offset;
    logic [12:0] found_name_len;
    logic [12:0] found_value_len;
    logic [31:0] found_hash;
    logic [12:0] compact_shift;
  } res_t;

endpackage

FILE: hw/rtl/hpack_dynamic_table_manager.sv
// HPACK dynamic table metadata manager. Pulse start while busy is low to issue
// one request word (insert, lookup, size update); exactly one result word comes
// back, shown for one cycle with valid_o high, and it must be taken then since
// the receiver cannot stall it. All entry metadata sits in one synchronous RAM
// with one read and one write port. A lookup reads the indexed entry, then
// returns it. An insert or size update first drops oldest entries while over
// the byte limit (an insert also while out of slots); an insert then compacts
// the live bytes when the tail room is short, rewriting every entry's offset at
// one entry per cycle, and places the entry if it then fits. An oversized
// insert, an invalid lookup index or an unknown request type never goes busy.
module hpack_dynamic_table_manager #(
  parameter int unsigned BYTE_CAP       = hdtm_pkg::BYTE_CAP_DEF,
  parameter int unsigned ENTRY_OVERHEAD = hdtm_pkg::ENTRY_OVERHEAD_DEF,
  parameter int unsigned ENTRY_SLOTS    = hdtm_pkg::ENTRY_SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  hdtm_pkg::req_t  req_i,
  output logic            valid_o,
  output hdtm_pkg::res_t  res_o
);

  localparam int unsigned SZ_W   = $clog2(BYTE_CAP + 1);
  localparam int unsigned SLOT_W = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRY_SLOTS + 1);
  localparam int unsigned BW     = hdtm_pkg::BYTES_W;
  localparam int unsigned EW     = hdtm_pkg::ESIZE_W;
  localparam int unsigned SW     = hdtm_pkg::SUM_W;

  typedef struct packed {
    logic [SZ_W-1:0] off;
    logic [SZ_W-1:0] nlen;
    logic [SZ_W-1:0] vlen;
    logic [31:0]     hash;
  } entry_t;

  // Ring index wrap for a sum below twice the slot count
  function automatic logic [SLOT_W-1:0] wrap(input logic [CNT_W:0] v);
    logic [CNT_W:0] r;
    r = (v >= (CNT_W+1)'(ENTRY_SLOTS)) ? v - (CNT_W+1)'(ENTRY_SLOTS) : v;
    return SLOT_W'(r);
  endfunction

  hdtm_pkg::state_e state_q, state_d;

  logic [SLOT_W-1:0] newest_q, newest_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SZ_W-1:0]   used_q, used_d;
  logic [SZ_W-1:0]   cap_q, cap_d;
  logic [SZ_W-1:0]   lbeg_q, lbeg_d;
  logic [SZ_W-1:0]   lend_q, lend_d;

  // Latched request
  logic              is_ins_q, is_ins_d;
  logic [BW-1:0]     bytes_q, bytes_d;
  logic [EW-1:0]     esize_q, esize_d;
  logic [SZ_W-1:0]   nlen_q, nlen_d;
  logic [SZ_W-1:0]   vlen_q, vlen_d;
  logic [31:0]       hash_q, hash_d;
  logic [CNT_W-1:0]  lkidx_q, lkidx_d;
  logic [SZ_W-1:0]   shift_q, shift_d;

  // Compaction walk
  logic [SLOT_W-1:0] caddr_q, caddr_d;
  logic [CNT_W-1:0]  cleft_q, cleft_d;
  logic              wbv_q, wbv_d;
  logic [SLOT_W-1:0] wbaddr_q, wbaddr_d;

  logic              valid_q, valid_d;
  hdtm_pkg::res_t    res_q, res_d;

  // Entry RAM
  entry_t            mem_q [ENTRY_SLOTS];
  entry_t            rd_q;
  logic [SLOT_W-1:0] raddr;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  entry_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Combinational helpers
  logic [BW-1:0]     in_bytes;
  logic [EW-1:0]     in_esize;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] new_slot;
  logic              fits_size;
  logic              tail_short;
  logic [SZ_W:0]     drop_bytes;
  logic [SZ_W-1:0]   tail_room;

  assign in_bytes   = BW'(req_i.name_bytes) + BW'(req_i.value_bytes);
  assign in_esize   = EW'(in_bytes) + EW'(ENTRY_OVERHEAD);
  assign oldest     = wrap((CNT_W+1)'(newest_q) + (CNT_W+1)'(count_q) - (CNT_W+1)'(1));
  assign new_slot   = (count_q == '0) ? '0 :
                      (newest_q == '0) ? SLOT_W'(ENTRY_SLOTS - 1) : newest_q - SLOT_W'(1);
  assign fits_size  = (SW'(used_q) + SW'(esize_q)) <= SW'(cap_q);
  assign tail_room  = SZ_W'(BYTE_CAP) - lend_q;
  assign tail_short = BW'(tail_room) < bytes_q;
  assign drop_bytes = (SZ_W+1)'(rd_q.nlen) + (SZ_W+1)'(rd_q.vlen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hdtm_pkg::ST_IDLE;
      newest_q <= '0;
      count_q  <= '0;
      used_q   <= '0;
      cap_q    <= SZ_W'(BYTE_CAP);
      lbeg_q   <= '0;
      lend_q   <= '0;
      wbv_q    <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      count_q  <= count_d;
      used_q   <= used_d;
      cap_q    <= cap_d;
      lbeg_q   <= lbeg_d;
      lend_q   <= lend_d;
      wbv_q    <= wbv_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_ins_q <= is_ins_d;
    bytes_q  <= bytes_d;
    esize_q  <= esize_d;
    nlen_q   <= nlen_d;
    vlen_q   <= vlen_d;
    hash_q   <= hash_d;
    lkidx_q  <= lkidx_d;
    shift_q  <= shift_d;
    caddr_q  <= caddr_d;
    cleft_q  <= cleft_d;
    wbaddr_q <= wbaddr_d;
    res_q    <= res_d;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    newest_d = newest_q;
    count_d  = count_q;
    used_d   = used_q;
    cap_d    = cap_q;
    lbeg_d   = lbeg_q;
    lend_d   = lend_q;
    is_ins_d = is_ins_q;
    bytes_d  = bytes_q;
    esize_d  = esize_q;
    nlen_d   = nlen_q;
    vlen_d   = vlen_q;
    hash_d   = hash_q;
    lkidx_d  = lkidx_q;
    shift_d  = shift_q;
    caddr_d  = caddr_q;
    cleft_d  = cleft_q;
    wbv_d    = 1'b0;
    wbaddr_d = wbaddr_q;
    valid_d  = 1'b0;
    res_d    = '0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;

    unique case (state_q)
      hdtm_pkg::ST_IDLE: begin
        if (start) begin
          is_ins_d = 1'b0;
          bytes_d  = in_bytes;
          esize_d  = in_esize;
          nlen_d   = SZ_W'(req_i.name_bytes);
          vlen_d   = SZ_W'(req_i.value_bytes);
          hash_d   = req_i.name_digest;
          lkidx_d  = CNT_W'(req_i.lookup_index);
          shift_d  = '0;
          case (req_i.req_type)
            hdtm_pkg::REQ_INSERT: begin
              if (EW'(in_esize) > EW'(cap_q)) begin
                // oversized entry empties the table
                count_d  = '0;
                used_d   = '0;
                newest_d = '0;
                lbeg_d   = '0;
                lend_d   = '0;
                valid_d  = 1'b1;
              end else begin
                is_ins_d = 1'b1;
                state_d  = hdtm_pkg::ST_EVICT;
              end
            end
            hdtm_pkg::REQ_LOOKUP: begin
              if (req_i.lookup_index == '0 ||
                  32'(req_i.lookup_index) > 32'(count_q)) begin
                valid_d = 1'b1;
              end else begin
                state_d = hdtm_pkg::ST_LOOKUP;
              end
            end
            hdtm_pkg::REQ_SIZE: begin
              cap_d   = (req_i.size_limit < 32'(BYTE_CAP)) ?
                        SZ_W'(req_i.size_limit) : SZ_W'(BYTE_CAP);
              esize_d = '0;
              state_d = hdtm_pkg::ST_EVICT;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      // drop oldest while over the limit or out of slots
      hdtm_pkg::ST_EVICT: begin
        if (count_q != '0 &&
            (!fits_size || (is_ins_q && count_q >= CNT_W'(ENTRY_SLOTS)))) begin
          raddr   = oldest;
          state_d = hdtm_pkg::ST_DROP;
        end else if (is_ins_q) begin
          state_d = hdtm_pkg::ST_TAIL;
        end else begin
          if (count_q == '0) begin
            lbeg_d = '0;
            lend_d = '0;
          end
          res_d.ok = 1'b1;
          valid_d  = 1'b1;
          state_d  = hdtm_pkg::ST_IDLE;
        end
      end

      hdtm_pkg::ST_DROP: begin
        if (count_q == CNT_W'(1)) begin
          count_d  = '0;
          used_d   = '0;
          newest_d = '0;
          lbeg_d   = '0;
          lend_d   = '0;
        end else begin
          count_d = count_q - CNT_W'(1);
          used_d  = used_q - SZ_W'(drop_bytes) - SZ_W'(ENTRY_OVERHEAD);
          lbeg_d  = lbeg_q + SZ_W'(drop_bytes);
        end
        state_d = hdtm_pkg::ST_EVICT;
      end

      // compaction decision
      hdtm_pkg::ST_TAIL: begin
        state_d = hdtm_pkg::ST_PLACE;
        if (tail_short) begin
          if (count_q == '0) begin
            lbeg_d = '0;
            lend_d = '0;
          end else if (lbeg_q != '0) begin
            shift_d = lbeg_q;
            caddr_d = newest_q;
            cleft_d = count_q;
            state_d = hdtm_pkg::ST_COMPACT;
          end
        end
      end

      // read each entry, write it back in the next cycle with offset moved down
      hdtm_pkg::ST_COMPACT: begin
        if (cleft_q != '0) begin
          raddr    = caddr_q;
          caddr_d  = (caddr_q == SLOT_W'(ENTRY_SLOTS - 1)) ? '0 : caddr_q + SLOT_W'(1);
          cleft_d  = cleft_q - CNT_W'(1);
          wbv_d    = 1'b1;
          wbaddr_d = caddr_q;
        end
        if (wbv_q) begin
          we        = 1'b1;
          waddr     = wbaddr_q;
          wdata     = rd_q;
          wdata.off = rd_q.off - shift_q;
        end
        if (cleft_q == '0 && !wbv_q) begin
          lend_d  = lend_q - shift_q;
          lbeg_d  = '0;
          state_d = hdtm_pkg::ST_PLACE;
        end
      end

      hdtm_pkg::ST_PLACE: begin
        res_d.compact_shift = 13'(shift_q);
        if (!tail_short) begin
          we         = 1'b1;
          waddr      = new_slot;
          wdata.off  = lend_q;
          wdata.nlen = nlen_q;
          wdata.vlen = vlen_q;
          wdata.hash = hash_q;
          res_d.ok          = 1'b1;
          res_d.data_offset = 12'(lend_q);
          lend_d   = lend_q + SZ_W'(bytes_q);
          newest_d = new_slot;
          count_d  = count_q + CNT_W'(1);
          used_d   = SZ_W'(SW'(used_q) + SW'(esize_q));
        end
        valid_d = 1'b1;
        state_d = hdtm_pkg::ST_IDLE;
      end

      hdtm_pkg::ST_LOOKUP: begin
        raddr   = wrap((CNT_W+1)'(newest_q) + (CNT_W+1)'(lkidx_q) - (CNT_W+1)'(1));
        state_d = hdtm_pkg::ST_LOOK_DONE;
      end

      hdtm_pkg::ST_LOOK_DONE: begin
        res_d.ok              = 1'b1;
        res_d.data_offset     = 12'(rd_q.off);
        res_d.found_name_len  = 13'(rd_q.nlen);
        res_d.found_value_len = 13'(rd_q.vlen);
        res_d.found_hash      = rd_q.hash;
        valid_d = 1'b1;
        state_d = hdtm_pkg::ST_IDLE;
      end

      default: begin
        state_d = hdtm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy    = (state_q != hdtm_pkg::ST_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
